/* src/tlnef_pkg.sv */
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants for the line-number / escape text filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

  localparam int NumberWidth = 6;
  // digits actually shown, limited to what the 24-bit BCD count holds
  localparam int Digits      = (NumberWidth < 1) ? 1 : ((NumberWidth > 6) ? 6 : NumberWidth);
  localparam int BcdWidth    = 24;
  localparam int MaxResults  = 8;
  localparam int PtrWidth    = $clog2(MaxResults);
  localparam int AddrWidth   = 2;

  localparam logic [AddrWidth-1:0] REG_FILTER_MODE = 2'd0;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  typedef enum logic [2:0] {
    MODE_PLAIN      = 3'd0,
    MODE_SQUEEZE    = 3'd1,
    MODE_NUM_NONBLK = 3'd2,
    MODE_NUM_ALL    = 3'd3,
    MODE_ENDS       = 3'd4,
    MODE_ENDS_CARET = 3'd5,
    MODE_TABS_CARET = 3'd6,
    MODE_TABS       = 3'd7
  } filter_mode_t;

endpackage

/* src/tlnef_in_if.sv */
// ----------------------------------------------------------------------------
// tlnef_in_if
// Input channel: one raw byte per item plus a file-start flag.
// ----------------------------------------------------------------------------
interface tlnef_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

/* src/tlnef_out_if.sv */
// ----------------------------------------------------------------------------
// tlnef_out_if
// Result channel: one output byte per item with a last marker.
// ----------------------------------------------------------------------------
interface tlnef_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* src/text_line_number_escape_filter.sv */
// ----------------------------------------------------------------------------
// text_line_number_escape_filter
// Byte-stream filter with line numbering, blank squeezing and escape modes.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  in_ch     | in  | valid/ready   | in_byte[7:0], file_start
//  out_ch    | out | valid/ready   | out_byte[7:0], last
//  cfg (APB) | in  | psel/penable  | paddr[1:0], pwdata[31:0], prdata[31:0]
//
//  An accepted byte is expanded combinationally into an 8-entry output buffer;
//  the buffer then drains one byte per cycle while out_ch is ready. A byte
//  yields 1 output byte passed through, 2 escaped or with a shown line end,
//  8 at a numbered line start (6 digits + tab + byte); a squeezed newline none.
//  The next byte is taken in the cycle the last buffered byte leaves.
//  Synchronous active-low reset; mode 0, line count 1, buffer empty.
//  out_ch stalls hold the buffer; in_ch stalls cost nothing.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  tlnef_in_if.sink                        in_ch,
  tlnef_out_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlnef_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tlnef_pkg::*;

  filter_mode_t          mode_r;
  logic                  prev_nl_r, prev_nl_nxt;
  logic                  squeezed_r, squeezed_nxt;
  logic [BcdWidth-1:0]   count_r, count_nxt;

  logic [7:0]            obuf_r [MaxResults];
  logic [7:0]            obuf_nxt [MaxResults];
  logic [PtrWidth-1:0]   ptr_r;
  logic [PtrWidth-1:0]   last_r, last_nxt;
  logic                  busy_r, busy_nxt;

  logic in_fire, out_fire, drain_done;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == REG_FILTER_MODE) ? {29'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
    end else if (psel && penable && pwrite && (paddr == REG_FILTER_MODE)) begin
      mode_r <= filter_mode_t'(pwdata[2:0]);
    end
  end

  // ---------------- handshakes ----------------
  assign drain_done   = out_ch.ready && (ptr_r == last_r);
  assign in_ch.ready  = !busy_r || drain_done;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign out_ch.valid = busy_r;
  assign out_ch.out_byte = obuf_r[ptr_r];
  assign out_ch.last  = (ptr_r == last_r);

  // ---------------- expansion of one item ----------------
  always_comb begin
    logic [7:0]          b;
    logic                at_start;
    logic                sq_in;
    logic [BcdWidth-1:0] cnt;
    logic                num_en;
    logic                drop;
    logic                two;
    logic                caret;
    logic [7:0]          c0, c1;
    logic                seen;
    logic                all_nines;
    logic                carry;
    logic [3:0]          d;
    logic [7:0]          dch [Digits];
    logic [BcdWidth-1:0] cnt_inc;

    b        = in_ch.in_byte;
    at_start = in_ch.file_start ? 1'b1 : prev_nl_r;
    sq_in    = in_ch.file_start ? 1'b0 : squeezed_r;
    cnt      = in_ch.file_start ? BcdWidth'(1) : count_r;

    num_en = at_start && ((mode_r == MODE_NUM_ALL) ||
                          ((mode_r == MODE_NUM_NONBLK) && (b != CH_NL)));
    drop   = 1'b0;
    two    = 1'b0;
    c0     = b;
    c1     = b;
    squeezed_nxt = sq_in;

    caret = ((b < CTRL_LIMIT) && (b != CH_TAB) && (b != CH_NL)) ||
            ((mode_r == MODE_TABS_CARET) && (b == CH_TAB));

    case (mode_r)
      MODE_SQUEEZE: begin
        if (at_start) begin
          if (b == CH_NL) begin
            if (sq_in) drop = 1'b1;
            squeezed_nxt = 1'b1;
          end else begin
            squeezed_nxt = 1'b0;
          end
        end
      end
      MODE_ENDS: begin
        if (b == CH_NL) begin
          two = 1'b1;
          c0  = CH_DOLLAR;
        end
      end
      MODE_ENDS_CARET, MODE_TABS_CARET: begin
        if (caret) begin
          two = 1'b1;
          c0  = CH_CARET;
          c1  = b + CARET_OFFSET;
        end else if (b == CH_DEL) begin
          two = 1'b1;
          c0  = CH_CARET;
          c1  = CH_QMARK;
        end else if ((mode_r == MODE_ENDS_CARET) && (b == CH_NL)) begin
          two = 1'b1;
          c0  = CH_DOLLAR;
        end
      end
      MODE_TABS: begin
        if (b == CH_TAB) begin
          two = 1'b1;
          c0  = CH_CARET;
          c1  = CH_UPPER_I;
        end
      end
      default: begin
      end
    endcase

    // number text: leading zeros shown as spaces, units digit always shown
    seen = 1'b0;
    for (int k = Digits - 1; k >= 0; k--) begin
      d = cnt[4*k +: 4];
      if (d > 4'd9) d = 4'd9;
      if ((d != 4'd0) || (k == 0)) seen = 1'b1;
      dch[Digits-1-k] = seen ? (CH_ZERO + {4'd0, d}) : CH_SPACE;
    end

    // saturating BCD increment over the shown digits
    all_nines = 1'b1;
    carry     = 1'b1;
    cnt_inc   = cnt;
    for (int k = 0; k < Digits; k++) begin
      d = cnt[4*k +: 4];
      if (d != 4'd9) all_nines = 1'b0;
      if (carry) begin
        if (d >= 4'd9) begin
          cnt_inc[4*k +: 4] = 4'd0;
        end else begin
          cnt_inc[4*k +: 4] = d + 4'd1;
          carry = 1'b0;
        end
      end
    end
    count_nxt = (num_en && !all_nines) ? cnt_inc : cnt;

    for (int i = 0; i < MaxResults; i++) begin
      obuf_nxt[i] = b;
    end
    if (num_en) begin
      for (int i = 0; i < Digits; i++) begin
        obuf_nxt[i] = dch[i];
      end
      obuf_nxt[Digits] = CH_TAB;
      last_nxt = PtrWidth'(Digits + 1);
    end else begin
      obuf_nxt[0] = c0;
      obuf_nxt[1] = c1;
      last_nxt = two ? PtrWidth'(1) : PtrWidth'(0);
    end

    prev_nl_nxt = (b == CH_NL);
    busy_nxt    = !drop;
  end

  // ---------------- state and output buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_nl_r  <= 1'b0;
      squeezed_r <= 1'b0;
      count_r    <= BcdWidth'(1);
      busy_r     <= 1'b0;
      ptr_r      <= '0;
      last_r     <= '0;
    end else if (in_fire) begin
      prev_nl_r  <= prev_nl_nxt;
      squeezed_r <= squeezed_nxt;
      count_r    <= count_nxt;
      busy_r     <= busy_nxt;
      ptr_r      <= '0;
      last_r     <= last_nxt;
    end else if (out_fire) begin
      if (ptr_r == last_r) begin
        busy_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + PtrWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MaxResults; i++) begin
        obuf_r[i] <= obuf_nxt[i];
      end
    end
  end

endmodule
